// ===== design/pts_pkg.sv =====
// Shared types, request codes and sequencer states for the periodic task scheduler table.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // Default number of task slots
  localparam int DEF_SLOT_COUNT = 8;

  // Width of handles, delays and periods
  localparam int DATA_W = 16;

  // Request kinds
  localparam logic [2:0] KIND_INIT     = 3'd0;
  localparam logic [2:0] KIND_DEINIT   = 3'd1;
  localparam logic [2:0] KIND_CREATE   = 3'd2;
  localparam logic [2:0] KIND_DELETE   = 3'd3;
  localparam logic [2:0] KIND_MODIFY   = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;
  localparam logic [2:0] KIND_DISPATCH = 3'd6;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Input word
  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        slot_index;
    logic [DATA_W-1:0] start_delay;
    logic [DATA_W-1:0] repeat_period;
    logic [DATA_W-1:0] task_handle;
  } req_t;

  // Result word
  typedef struct packed {
    logic              status;
    logic [7:0]        result_slot;
    logic [DATA_W-1:0] result_handle;
    logic              task_found;
  } rsp_t;

  // One slot as held in the slot memory
  typedef struct packed {
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] delay;
    logic [DATA_W-1:0] period;
  } entry_t;

  // Tick update of one slot
  typedef struct packed {
    logic [DATA_W-1:0] delay;
    logic              due;
  } tick_upd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_FREE,
    ST_SCAN_READY,
    ST_DISP_READ,
    ST_TICK,
    ST_TICK_LAST,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/pts_slot_mem.sv =====
// Slot memory: handle, delay and period of each task slot, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pts_slot_mem
  import pts_pkg::*;
#(
  parameter int DEPTH  = DEF_SLOT_COUNT,
  parameter int ADDR_W = 3
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pts_slot_alu.sv =====
// Shared slot unit: ages one slot's delay on a tick or reloads it from the period when due.
`timescale 1ns / 1ps
`default_nettype none

module pts_slot_alu
  import pts_pkg::*;
(
  input  wire entry_t cur,
  output tick_upd_t   upd
);

  // Reload from the period when due (a zero period keeps the delay at zero)
  always_comb begin
    upd.due   = (cur.delay == '0);
    upd.delay = upd.due ? cur.period : (cur.delay - DATA_W'(1));
  end

endmodule

`default_nettype wire

// ===== design/periodic_task_scheduler_table.sv =====
// Top level of the periodic task scheduler table: handshakes, sequencer and slot flags.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_ready  | in_data   (req_t request)
//   out     | output    | out_valid / out_ready| out_data  (rsp_t result)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_data  (scheduler enable bit)
//
// Init, deinit, delete, modify, an unused kind and suspended tick or dispatch pass
// only through the decode and done states. Create steps through the slot flags one
// slot per cycle; dispatch scans the same way and then reads the slot memory; tick
// streams every slot through the slot memory read port and the shared slot unit.
// in_ready rises with out_valid. Reset clears the occupied and ready flags at once;
// the slot memory needs no clearing. A result waiting on out_ready holds in the output
// register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_scheduler_table
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  state_t                  state, state_next;
  req_t                    req;
  logic [IDX_W-1:0]        cnt, cnt_next;
  logic [SLOT_COUNT-1:0]   occupied, occupied_next;
  logic [SLOT_COUNT-1:0]   ready_mask, ready_mask_next;
  logic                    initialized, initialized_next;
  logic                    enable;
  rsp_t                    rsp, rsp_next;
  logic                    tick_wr, tick_wr_next;
  logic [IDX_W-1:0]        tick_addr;

  logic [IDX_W-1:0]        idx;
  logic                    slot_ok;
  logic                    load_out;

  logic                    mem_wr_en;
  logic [IDX_W-1:0]        mem_wr_addr;
  entry_t                  mem_wr_data;
  logic                    mem_rd_en;
  entry_t                  mem_rd_data;
  tick_upd_t               upd;

  pts_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt),
    .rd_data (mem_rd_data)
  );

  pts_slot_alu u_alu (
    .cur (mem_rd_data),
    .upd (upd)
  );

  // Check the addressed slot for delete and modify
  assign idx      = req.slot_index[IDX_W-1:0];
  assign slot_ok  = (req.slot_index < 8'(SLOT_COUNT)) && occupied[idx];
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (req.kind)
          KIND_CREATE: begin
            state_next = (req.task_handle == '0) ? ST_DONE : ST_SCAN_FREE;
          end
          KIND_TICK: begin
            state_next = enable ? ST_TICK : ST_DONE;
          end
          KIND_DISPATCH: begin
            state_next = enable ? ST_SCAN_READY : ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SCAN_FREE: begin
        if (!occupied[cnt] || cnt == LAST_SLOT) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_READY: begin
        if (ready_mask[cnt]) begin
          state_next = ST_DISP_READ;
        end else if (cnt == LAST_SLOT) begin
          state_next = ST_DONE;
        end
      end
      ST_DISP_READ: begin
        state_next = ST_DONE;
      end
      ST_TICK: begin
        if (cnt == LAST_SLOT) begin
          state_next = ST_TICK_LAST;
        end
      end
      ST_TICK_LAST: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath controls, flag updates and result
  always_comb begin
    in_ready         = (state == ST_IDLE);
    cnt_next         = cnt;
    occupied_next    = occupied;
    ready_mask_next  = ready_mask;
    initialized_next = initialized;
    rsp_next         = rsp;
    tick_wr_next     = (state == ST_TICK);
    mem_wr_en        = 1'b0;
    mem_wr_addr      = cnt;
    mem_wr_data      = '{handle: req.task_handle, delay: req.start_delay,
                         period: req.repeat_period};
    mem_rd_en        = 1'b0;

    // Write back the slot read in the previous tick cycle
    if (tick_wr && occupied[tick_addr]) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = tick_addr;
      mem_wr_data = '{handle: mem_rd_data.handle, delay: upd.delay,
                      period: mem_rd_data.period};
      if (upd.due) begin
        ready_mask_next[tick_addr] = 1'b1;
      end
    end

    case (state)
      ST_IDLE: begin
        cnt_next = '0;
      end
      ST_DECODE: begin
        rsp_next = '0;
        case (req.kind)
          KIND_INIT: begin
            if (initialized) begin
              rsp_next.status = STATUS_INVALID;
            end else begin
              occupied_next    = '0;
              ready_mask_next  = '0;
              initialized_next = 1'b1;
            end
          end
          KIND_DEINIT: begin
            if (!initialized) begin
              rsp_next.status = STATUS_INVALID;
            end else begin
              occupied_next    = '0;
              ready_mask_next  = '0;
              initialized_next = 1'b0;
            end
          end
          KIND_CREATE: begin
            if (req.task_handle == '0) begin
              rsp_next.status = STATUS_INVALID;
            end
          end
          KIND_DELETE: begin
            if (!slot_ok) begin
              rsp_next.status = STATUS_INVALID;
            end else begin
              occupied_next[idx]   = 1'b0;
              ready_mask_next[idx] = 1'b0;
            end
          end
          KIND_MODIFY: begin
            if (!slot_ok || req.task_handle == '0) begin
              rsp_next.status = STATUS_INVALID;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = idx;
            end
          end
          KIND_TICK, KIND_DISPATCH: begin
            rsp_next.status = STATUS_OK;
          end
          default: begin
            rsp_next.status = STATUS_INVALID;
          end
        endcase
      end
      // Take the lowest free slot
      ST_SCAN_FREE: begin
        if (!occupied[cnt]) begin
          mem_wr_en            = 1'b1;
          mem_wr_addr          = cnt;
          occupied_next[cnt]   = 1'b1;
          ready_mask_next[cnt] = 1'b0;
          rsp_next.result_slot = 8'(cnt);
        end else if (cnt == LAST_SLOT) begin
          rsp_next.status = STATUS_INVALID;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      // Find the lowest ready slot and fetch its entry
      ST_SCAN_READY: begin
        if (ready_mask[cnt]) begin
          mem_rd_en            = 1'b1;
          ready_mask_next[cnt] = 1'b0;
        end else if (cnt != LAST_SLOT) begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      // Report the dispatched task, drop it when it is one-shot
      ST_DISP_READ: begin
        rsp_next.task_found    = 1'b1;
        rsp_next.result_slot   = 8'(cnt);
        rsp_next.result_handle = mem_rd_data.handle;
        if (mem_rd_data.period == '0) begin
          occupied_next[cnt] = 1'b0;
        end
      end
      // Stream every slot through the shared unit
      ST_TICK: begin
        mem_rd_en = 1'b1;
        if (cnt != LAST_SLOT) begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      occupied    <= '0;
      ready_mask  <= '0;
      initialized <= 1'b0;
      enable      <= 1'b1;
      tick_wr     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      occupied    <= occupied_next;
      ready_mask  <= ready_mask_next;
      initialized <= initialized_next;
      tick_wr     <= tick_wr_next;
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    cnt       <= cnt_next;
    rsp       <= rsp_next;
    tick_addr <= cnt;
    if (load_out) begin
      out_data <= rsp;
    end
  end

endmodule

`default_nettype wire

// ===== design/pts_checker.sv =====
// Port checker for the periodic task scheduler table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pts_checker
  import pts_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Come out of reset ready for a request
  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

  // Drop ready in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  // A found task is never reported with an invalid status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.task_found && out_data.status == STATUS_INVALID))
    else $error("found task with invalid status");

  // Report a handle only for a found task
  a_handle_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.task_found |-> out_data.result_handle == '0)
    else $error("handle reported without a found task");

endmodule

bind periodic_task_scheduler_table pts_checker u_pts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
